/* rtl/websocket_frame_decoder_macros.svh */
// Assertion macros for the WebSocket frame decoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef WEBSOCKET_FRAME_DECODER_MACROS_SVH
`define WEBSOCKET_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsfd assertion failed");

// Next-cycle implication, disabled during reset.
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsfd assertion failed");

`endif

/* rtl/wsfd_pkg.sv */
// Shared types and constants for the WebSocket frame decoder.
// No dependencies; imported by wsfd_result_queue and websocket_frame_decoder.
package wsfd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } wsfd_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        final_flag;
    logic [3:0]  frame_kind_code;
    logic        mask_present;
    logic [63:0] frame_length;
    logic [31:0] mask_word;
    logic [7:0]  payload_byte;
    logic [1:0]  error_kind;
    logic [63:0] consumed_count;
    logic        last_of_frame;
  } wsfd_result_t;

  // Push strobes into the result queue; second is only set with first.
  typedef struct packed {
    logic first;
    logic second;
  } wsfd_push_t;

  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_REQUIRE_MASK = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD  = 4'd1;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd1;
  localparam logic [1:0] ERR_OPCODE     = 2'd2;

  localparam logic [3:0] OP_CONTINUATION = 4'h0;
  localparam logic [3:0] OP_TEXT         = 4'h1;
  localparam logic [3:0] OP_BINARY       = 4'h2;
  localparam logic [3:0] OP_CLOSE        = 4'h8;
  localparam logic [3:0] OP_PING         = 4'h9;
  localparam logic [3:0] OP_PONG         = 4'hA;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

endpackage

/* rtl/websocket_frame_decoder.sv */
// WebSocket frame decoder: one byte per transaction, header, unmasked payload and errors out.
// Latency: results enter the output queue at the accepting edge, visible the next cycle.
// Throughput: one byte per cycle unless stalled; a byte's up to two results fit the queue.
// item_ready drops while the result queue holds more than QUEUE_DEPTH-2 entries.
// Reset clears the parser to wait for a first header byte; require_mask 0, limit all ones.
// Depends on wsfd_pkg, wsfd_result_queue and websocket_frame_decoder_macros.svh.
`include "websocket_frame_decoder_macros.svh"

module websocket_frame_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  wsfd_pkg::wsfd_item_t                  item,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output wsfd_pkg::wsfd_result_t                result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wsfd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [31:0]                           cfg_data
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_EXT,
    PH_KEY,
    PH_PAY,
    PH_SKIP
  } phase_t;

  // configuration
  logic        require_mask;
  logic [31:0] max_payload_length;

  // parser state
  phase_t      phase, phase_next;
  logic [7:0]  first_header_byte, first_header_byte_next;
  logic [63:0] length_accumulator, length_accumulator_next;
  logic [3:0]  extension_bytes_left, extension_bytes_left_next;
  logic [31:0] mask_key_store, mask_key_store_next;
  logic [2:0]  mask_bytes_left, mask_bytes_left_next;
  logic [63:0] payload_remaining, payload_remaining_next;
  logic [1:0]  key_index, key_index_next;
  logic [63:0] frame_byte_count, frame_byte_count_next;
  logic        mask_flag, mask_flag_next;

  logic         accept;
  logic [7:0]   b;
  logic         eob;
  logic [63:0]  count_inc;
  logic [1:0]   err;
  logic         length_done;
  logic         header_done;
  logic         hdr_emit;
  logic         hdr_last;
  logic         pay_emit;
  logic         pay_last;
  logic [7:0]   pay_byte;
  logic [7:0]   key_byte;
  logic         prim_valid;
  logic         err_valid;
  wsfd_result_t prim_res;
  wsfd_result_t err_res;
  wsfd_result_t first_res;
  wsfd_push_t   push;
  logic         queue_room;

  function automatic logic opcode_ok(input logic [3:0] op);
    return op == OP_CONTINUATION || op == OP_TEXT || op == OP_BINARY ||
           op == OP_CLOSE || op == OP_PING || op == OP_PONG;
  endfunction

  assign accept     = item_valid && item_ready;
  assign item_ready = queue_room;
  assign cfg_ready  = 1'b1;
  assign b          = item.data_byte;
  assign eob        = item.end_of_buffer;
  assign count_inc  = (frame_byte_count == '1) ? frame_byte_count
                                                : frame_byte_count + 64'd1;
  assign key_byte   = mask_key_store[{~key_index, 3'b000} +: 8];

  always_comb begin
    phase_next                = phase;
    first_header_byte_next    = first_header_byte;
    length_accumulator_next   = length_accumulator;
    extension_bytes_left_next = extension_bytes_left;
    mask_key_store_next       = mask_key_store;
    mask_bytes_left_next      = mask_bytes_left;
    payload_remaining_next    = payload_remaining;
    key_index_next            = key_index;
    frame_byte_count_next     = frame_byte_count;
    mask_flag_next            = mask_flag;
    err         = ERR_NONE;
    length_done = 1'b0;
    header_done = 1'b0;
    hdr_emit    = 1'b0;
    hdr_last    = 1'b0;
    pay_emit    = 1'b0;
    pay_last    = 1'b0;
    pay_byte    = '0;

    if (accept) begin
      unique case (phase)
        PH_SKIP: begin
          if (eob) begin
            phase_next = PH_IDLE;
          end
        end
        PH_IDLE: begin
          first_header_byte_next    = b;
          length_accumulator_next   = '0;
          extension_bytes_left_next = '0;
          mask_key_store_next       = '0;
          mask_bytes_left_next      = '0;
          payload_remaining_next    = '0;
          key_index_next            = '0;
          mask_flag_next            = 1'b0;
          frame_byte_count_next     = 64'd1;
          phase_next                = PH_LEN;
        end
        PH_LEN: begin
          frame_byte_count_next = count_inc;
          if (!opcode_ok(first_header_byte[3:0])) begin
            err = ERR_OPCODE;
          end else begin
            mask_flag_next = b[7];
            if (b[6:0] == LEN_CODE_EXT16 || b[6:0] == LEN_CODE_EXT64) begin
              extension_bytes_left_next = (b[6:0] == LEN_CODE_EXT16) ? 4'd2 : 4'd8;
              length_accumulator_next   = '0;
              phase_next                = PH_EXT;
            end else begin
              length_accumulator_next = {57'd0, b[6:0]};
              length_done             = 1'b1;
            end
          end
        end
        PH_EXT: begin
          frame_byte_count_next     = count_inc;
          length_accumulator_next   = {length_accumulator[55:0], b};
          extension_bytes_left_next = extension_bytes_left - 4'd1;
          length_done               = (extension_bytes_left_next == '0);
        end
        PH_KEY: begin
          frame_byte_count_next = count_inc;
          mask_key_store_next   = {mask_key_store[23:0], b};
          mask_bytes_left_next  = mask_bytes_left - 3'd1;
          header_done           = (mask_bytes_left_next == '0);
        end
        PH_PAY: begin
          frame_byte_count_next  = count_inc;
          pay_byte               = mask_flag ? (b ^ key_byte) : b;
          key_index_next         = key_index + 2'd1;
          payload_remaining_next = payload_remaining - 64'd1;
          pay_last               = (payload_remaining_next == '0);
          pay_emit               = 1'b1;
          if (pay_last) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          frame_byte_count_next = count_inc;
          phase_next            = PH_IDLE;
        end
      endcase

      if (length_done) begin
        if (require_mask && !mask_flag_next) begin
          err = ERR_INCOMPLETE;
        end else if (mask_flag_next) begin
          mask_bytes_left_next = 3'd4;
          mask_key_store_next  = '0;
          phase_next           = PH_KEY;
        end else begin
          header_done = 1'b1;
        end
      end

      if (header_done) begin
        if (length_accumulator_next > {32'd0, max_payload_length}) begin
          err = ERR_INCOMPLETE;
        end else if (length_accumulator_next == '0) begin
          hdr_emit   = 1'b1;
          hdr_last   = 1'b1;
          phase_next = PH_IDLE;
        end else if (eob) begin
          err = ERR_INCOMPLETE;
        end else begin
          hdr_emit               = 1'b1;
          payload_remaining_next = length_accumulator_next;
          key_index_next         = '0;
          phase_next             = PH_PAY;
        end
      end

      if (phase != PH_SKIP) begin
        if (err == ERR_NONE && eob && phase_next != PH_IDLE) begin
          err = ERR_INCOMPLETE;
        end
        if (err != ERR_NONE) begin
          frame_byte_count_next = '0;
          phase_next            = eob ? PH_IDLE : PH_SKIP;
        end
      end
    end
  end

  always_comb begin
    prim_res.result_kind     = pay_emit ? KIND_PAYLOAD : KIND_HEADER;
    prim_res.final_flag      = first_header_byte_next[7];
    prim_res.frame_kind_code = first_header_byte_next[3:0];
    prim_res.mask_present    = mask_flag_next;
    prim_res.frame_length    = length_accumulator_next;
    prim_res.mask_word       = mask_flag_next ? mask_key_store_next : '0;
    prim_res.payload_byte    = pay_byte;
    prim_res.error_kind      = ERR_NONE;
    prim_res.consumed_count  = count_inc;
    prim_res.last_of_frame   = pay_emit ? pay_last : hdr_last;

    err_res                = '0;
    err_res.result_kind    = KIND_ERROR;
    err_res.error_kind     = err;
    err_res.last_of_frame  = 1'b1;
  end

  assign prim_valid   = hdr_emit || pay_emit;
  assign err_valid    = (err != ERR_NONE);
  assign first_res    = prim_valid ? prim_res : err_res;
  assign push.first   = prim_valid || err_valid;
  assign push.second  = prim_valid && err_valid;

  wsfd_result_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .first_data  (first_res),
    .second_data (err_res),
    .room        (queue_room),
    .valid       (result_valid),
    .ready       (result_ready),
    .data        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      require_mask         <= 1'b0;
      max_payload_length   <= '1;
      phase                <= PH_IDLE;
      first_header_byte    <= '0;
      length_accumulator   <= '0;
      extension_bytes_left <= '0;
      mask_key_store       <= '0;
      mask_bytes_left      <= '0;
      payload_remaining    <= '0;
      key_index            <= '0;
      frame_byte_count     <= '0;
      mask_flag            <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_REQUIRE_MASK) begin
          require_mask <= cfg_data[0];
        end else if (cfg_index == CFG_MAX_PAYLOAD) begin
          max_payload_length <= cfg_data;
        end
      end
      phase                <= phase_next;
      first_header_byte    <= first_header_byte_next;
      length_accumulator   <= length_accumulator_next;
      extension_bytes_left <= extension_bytes_left_next;
      mask_key_store       <= mask_key_store_next;
      mask_bytes_left      <= mask_bytes_left_next;
      payload_remaining    <= payload_remaining_next;
      key_index            <= key_index_next;
      frame_byte_count     <= frame_byte_count_next;
      mask_flag            <= mask_flag_next;
    end
  end

  `WSFD_ASSERT_IMPL(a_skip_silent, clk, rst, accept && phase == PH_SKIP, !push.first)
  `WSFD_ASSERT_IMPL(a_second_is_error, clk, rst, push.second,
                    err_res.result_kind == KIND_ERROR && err_res.last_of_frame)
  `WSFD_ASSERT_NEXT(a_eob_idles, clk, rst, accept && eob, phase == PH_IDLE)
  `WSFD_ASSERT_IMPL(a_pay_nonzero, clk, rst, phase == PH_PAY, payload_remaining != '0)

endmodule

/* rtl/wsfd_result_queue.sv */
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on wsfd_pkg.
module wsfd_result_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wsfd_pkg::wsfd_push_t  push,
  input  wsfd_pkg::wsfd_result_t first_data,
  input  wsfd_pkg::wsfd_result_t second_data,
  output logic                  room,
  output logic                  valid,
  input  logic                  ready,
  output wsfd_pkg::wsfd_result_t data
);
  import wsfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsfd_result_t             entries [DEPTH];
  logic [PTR_W-1:0]         rd_ptr;
  logic [PTR_W-1:0]         wr_ptr;
  logic [CNT_W-1:0]         count;
  logic [PTR_W-1:0]         wr_ptr_plus1;
  logic                     pop;
  logic [CNT_W-1:0]         push_cnt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign wr_ptr_plus1 = ptr_inc(wr_ptr);
  assign pop          = valid && ready;
  assign push_cnt     = CNT_W'(push.first) + CNT_W'(push.second);
  assign valid        = (count != '0);
  assign data         = entries[rd_ptr];
  assign room         = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wr_ptr] <= first_data;
    end
    if (push.second) begin
      entries[wr_ptr_plus1] <= second_data;
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push.second) begin
        wr_ptr <= ptr_inc(wr_ptr_plus1);
      end else if (push.first) begin
        wr_ptr <= wr_ptr_plus1;
      end
      count <= count + push_cnt - CNT_W'(pop);
    end
  end

endmodule
